@@ design/bpn_pkg.sv @@
// Shared types and constants for the five-class posterior normalizer.
`default_nettype none
package bpn_pkg;
  localparam int NCLASS     = 5;
  localparam int W_Q        = 16;
  localparam int W_PROD     = 32;
  localparam int W_SUM      = 35;
  localparam int W_REM      = 36;
  localparam int W_QUOT     = 17;
  localparam int NSTEP      = 17;
  localparam int FIFO_DEPTH = 4;
  localparam int W_CNT      = 3;
  localparam int W_IDX      = 3;
  localparam logic [W_Q-1:0] UNIFORM_Q16 = 16'd13107;
  localparam logic [W_Q-1:0] MAX_Q16     = 16'hFFFF;

  typedef enum logic [W_IDX-1:0] {
    REG_PRIOR_ELECTRON = 3'd0,
    REG_PRIOR_MUON     = 3'd1,
    REG_PRIOR_PION     = 3'd2,
    REG_PRIOR_KAON     = 3'd3,
    REG_PRIOR_PROTON   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [W_Q-1:0] weight_electron;
    logic [W_Q-1:0] weight_muon;
    logic [W_Q-1:0] weight_pion;
    logic [W_Q-1:0] weight_kaon;
    logic [W_Q-1:0] weight_proton;
  } in_req_t;

  typedef struct packed {
    logic [W_Q-1:0] post_electron;
    logic [W_Q-1:0] post_muon;
    logic [W_Q-1:0] post_pion;
    logic [W_Q-1:0] post_kaon;
    logic [W_Q-1:0] post_proton;
    logic           ok;
  } out_res_t;

  typedef struct packed {
    logic [NCLASS-1:0][W_PROD-1:0] prod;
    logic [W_SUM-1:0]              sum;
    logic                          zero;
  } job_t;

  typedef struct packed {
    logic [NCLASS-1:0][W_REM-1:0]  rem;
    logic [NCLASS-1:0][W_QUOT-1:0] quot;
    logic [W_SUM-1:0]              den;
    logic                          zero;
  } div_stage_t;
endpackage
`default_nettype wire

@@ design/bpn_front.sv @@
// Front end: prior registers, products, sum and zero-sum classification.
`default_nettype none
module bpn_front import bpn_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  input  wire logic [W_IDX-1:0] cfg_index,
  input  wire logic [W_Q-1:0]   cfg_data,
  input  wire logic             in_fire,
  input  wire in_req_t          in_data,
  output logic [1:0]            inflight,
  output logic                  push,
  output job_t                  push_job
);
  logic [NCLASS-1:0][W_Q-1:0]    prior_r;
  logic [NCLASS-1:0][W_Q-1:0]    w;
  logic [NCLASS-1:0][W_PROD-1:0] prod_r;
  logic                          v1_r, v2_r;
  job_t                          job_r;
  logic [W_SUM-1:0]              sum_nxt;

  assign w = {in_data.weight_electron, in_data.weight_muon, in_data.weight_pion,
              in_data.weight_kaon, in_data.weight_proton};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PRIOR_ELECTRON: prior_r[4] <= cfg_data;
        REG_PRIOR_MUON:     prior_r[3] <= cfg_data;
        REG_PRIOR_PION:     prior_r[2] <= cfg_data;
        REG_PRIOR_KAON:     prior_r[1] <= cfg_data;
        REG_PRIOR_PROTON:   prior_r[0] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < NCLASS; k++) sum_nxt = sum_nxt + W_SUM'(prod_r[k]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_fire;
      v2_r <= v1_r;
    end
    for (int k = 0; k < NCLASS; k++) prod_r[k] <= w[k] * prior_r[k];
    job_r.prod <= prod_r;
    job_r.sum  <= sum_nxt;
    job_r.zero <= (sum_nxt == '0);
  end

  assign inflight = {1'b0, v1_r} + {1'b0, v2_r};
  assign push     = v2_r;
  assign push_job = job_r;
endmodule
`default_nettype wire

@@ design/bpn_fifo.sv @@
// Short request queue between front end and divider.
`default_nettype none
module bpn_fifo import bpn_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire job_t        push_job,
  input  wire logic        pop,
  output logic             not_empty,
  output job_t             head,
  output logic [W_CNT-1:0] cnt
);
  job_t               mem [FIFO_DEPTH];
  logic [W_CNT-2:0]   wp_r, rp_r;
  logic [W_CNT-1:0]   cnt_r;
  logic               do_pop;

  assign do_pop    = pop && (cnt_r != '0);
  assign not_empty = (cnt_r != '0);
  assign head      = mem[rp_r];
  assign cnt       = cnt_r;

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_job;
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push)   wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + W_CNT'(push) - W_CNT'(do_pop);
    end
  end
endmodule
`default_nettype wire

@@ design/bpn_back.sv @@
// Back end: pipelined restoring divider, one quotient bit per stage, and output register.
`default_nettype none
module bpn_back import bpn_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      job_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_res_t  out_data
);
  div_stage_t             s_r [NSTEP+1];
  div_stage_t             s_nxt [NSTEP+1];
  logic [NSTEP:0]         v_r;
  logic                   adv;
  logic                   out_v_r;
  out_res_t               out_r, out_nxt;
  logic [NCLASS-1:0][W_Q-1:0] post;
  logic [W_REM-1:0]       r, d;

  assign adv     = !out_v_r || out_ready;
  assign job_pop = adv && job_valid;

  always_comb begin
    s_nxt[0].den  = job.sum;
    s_nxt[0].zero = job.zero;
    for (int c = 0; c < NCLASS; c++) begin
      s_nxt[0].rem[c]  = W_REM'(job.prod[c]);
      s_nxt[0].quot[c] = '0;
    end
    d = W_REM'(job.sum);
    r = '0;
    for (int k = 0; k < NSTEP; k++) begin
      s_nxt[k+1].den  = s_r[k].den;
      s_nxt[k+1].zero = s_r[k].zero;
      d = W_REM'(s_r[k].den);
      for (int c = 0; c < NCLASS; c++) begin
        r = (k == 0) ? s_r[k].rem[c] : {s_r[k].rem[c][W_REM-2:0], 1'b0};
        if (r >= d) begin
          s_nxt[k+1].rem[c]  = r - d;
          s_nxt[k+1].quot[c] = {s_r[k].quot[c][W_QUOT-2:0], 1'b1};
        end else begin
          s_nxt[k+1].rem[c]  = r;
          s_nxt[k+1].quot[c] = {s_r[k].quot[c][W_QUOT-2:0], 1'b0};
        end
      end
    end
    for (int c = 0; c < NCLASS; c++) begin
      if (s_r[NSTEP].zero)             post[c] = UNIFORM_Q16;
      else if (s_r[NSTEP].quot[c][W_QUOT-1]) post[c] = MAX_Q16;
      else                             post[c] = s_r[NSTEP].quot[c][W_Q-1:0];
    end
    out_nxt = {post[4], post[3], post[2], post[1], post[0], !s_r[NSTEP].zero};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r     <= '0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      v_r     <= {v_r[NSTEP-1:0], job_valid};
      out_v_r <= v_r[NSTEP];
    end
    if (adv) begin
      for (int k = 0; k <= NSTEP; k++) s_r[k] <= s_nxt[k];
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;
endmodule
`default_nettype wire

@@ design/bayes_posterior_normalizer_core.sv @@
// Top level of the five-class Bayesian posterior normalizer.
//  channel | valid     | ready     | payload
//  input   | in_valid  | in_ready  | in_data (in_req_t)
//  result  | out_valid | out_ready | out_data (out_res_t)
//  config  | cfg_valid | cfg_ready | cfg_index, cfg_data
// One request per cycle sustained while out_ready stays high.
// Front: multiply stage and sum stage; back: 17 divider stages, one per quotient bit.
// A 4-entry queue sits between them; in_ready drops when queue plus front is full.
// Synchronous active-low reset clears priors and all valid state.
`default_nettype none
module bayes_posterior_normalizer_core import bpn_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_req_t          in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_res_t              out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [W_IDX-1:0] cfg_index,
  input  wire logic [W_Q-1:0]   cfg_data
);
  logic [1:0]       inflight;
  logic             push, pop, not_empty;
  job_t             push_job, head;
  logic [W_CNT-1:0] cnt;
  logic             in_fire;

  assign cfg_ready = 1'b1;
  assign in_ready  = (cnt + W_CNT'(inflight)) < W_CNT'(FIFO_DEPTH);
  assign in_fire   = in_valid && in_ready;

  bpn_front u_front (
    .clk, .rst_n, .cfg_valid, .cfg_index, .cfg_data,
    .in_fire, .in_data, .inflight, .push, .push_job
  );

  bpn_fifo u_fifo (
    .clk, .rst_n, .push, .push_job, .pop, .not_empty, .head, .cnt
  );

  bpn_back u_back (
    .clk, .rst_n, .job_valid(not_empty), .job(head), .job_pop(pop),
    .out_valid, .out_ready, .out_data
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && !pop && cnt == W_CNT'(FIFO_DEPTH)))
    else $error("queue overflow");

  a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.ok) |-> (out_data.post_electron == UNIFORM_Q16 &&
      out_data.post_muon == UNIFORM_Q16 && out_data.post_pion == UNIFORM_Q16 &&
      out_data.post_kaon == UNIFORM_Q16 && out_data.post_proton == UNIFORM_Q16))
    else $error("fallback not uniform");
endmodule
`default_nettype wire
